@@ design/pttt_pkg.sv @@
// Package for the priority task timer table: sizes, mode and status codes, entry type.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none
package pttt_pkg;
   localparam int TABLE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DISP_W = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_TOUCH = 3'd2;
   localparam logic [2:0] MODE_TICK = 3'd3;
   localparam logic [2:0] MODE_UPDATE = 3'd4;
   localparam logic [2:0] MODE_EXISTS = 3'd5;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [7:0] id;
      logic [15:0] interval;
      logic [15:0] countdown;
      logic rpt;
      logic [7:0] prio;
      logic active;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

@@ design/pttt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// Stands alone; used by the timer table top level for the entry store.
`default_nettype none
module pttt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/priority_task_timer_table.sv @@
// Priority task timer table: top level with the sequencer that walks the entry RAM.
// Depends on pttt_pkg and pttt_ram.
// An add walks one entry past the table; an update walks the table twice.
// Throughput: one command at a time; busy stays high until its last result word is out.
// Reset empties the table and clears the tick counter; the receiver cannot stall results.
`default_nettype none
module priority_task_timer_table
   import pttt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [2:0] req_mode,
   input wire logic [7:0] req_task_id,
   input wire logic [15:0] req_interval,
   input wire logic req_repeat_req,
   input wire logic [7:0] req_priority_req,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic rsp_dispatch_valid,
   output logic [7:0] rsp_dispatch_id,
   output logic rsp_found,
   output logic [3:0] rsp_slot,
   output logic [4:0] rsp_task_count,
   output logic [31:0] rsp_elapsed_time,
   output logic rsp_last
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_DONE
   } state_type;

   state_type state_ff;
   logic [2:0] mode_ff;
   logic [7:0] id_ff, pri_ff;
   logic [15:0] ivl_ff;
   logic rep_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0] ticks_ff;
   // i_ff: read position; w_ff: write position (lags i_ff by the removals so far).
   logic [CNT_W-1:0] i_ff, w_ff;
   logic [CNT_W-1:0] pos_ff;
   logic hit_ff;
   logic [DISP_W-1:0] ndisp_ff;
   logic [1:0] status_ff;
   logic [IDX_W-1:0] slot_ff;
   logic found_ff;
   entry_type carry_ff;
   logic pend_ff;
   logic [7:0] pid_ff;
   // An update first counts the one-shot entries it will drop, then walks again to dispatch.
   logic pass_ff;
   logic [CNT_W-1:0] drop_ff;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   pttt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   entry_type new_e, cur;
   logic in_range;
   always_comb begin
      new_e = '{id: id_ff, interval: ivl_ff, countdown: ivl_ff, rpt: rep_ff,
                prio: pri_ff, active: 1'b0};
      rd_addr = i_ff[IDX_W-1:0];
      in_range = i_ff < count_ff;
      wr_en = 1'b0;
      wr_addr = w_ff[IDX_W-1:0];
      cur = rd_data;
      wr_data = cur;
      if (state_ff == ST_EVAL) begin
         case (mode_ff)
            MODE_ADD: begin
               wr_en = 1'b1;
               wr_addr = i_ff[IDX_W-1:0];
               if (!hit_ff && (!in_range || cur.prio > pri_ff)) begin
                  wr_data = new_e;
               end else if (hit_ff) begin
                  wr_data = carry_ff;
               end else begin
                  wr_en = 1'b0;
               end
            end
            MODE_REMOVE: begin
               wr_en = hit_ff;
            end
            MODE_TOUCH: begin
               wr_en = !hit_ff && cur.id == id_ff;
               wr_addr = i_ff[IDX_W-1:0];
               wr_data.countdown = '0;
            end
            MODE_TICK: begin
               wr_en = 1'b1;
               if (cur.active && cur.countdown != '0) begin
                  wr_data.countdown = cur.countdown - 16'd1;
               end
            end
            MODE_UPDATE: begin
               if (pass_ff) begin
                  wr_data.active = 1'b1;
                  if (cur.countdown == '0 && ndisp_ff < DISP_W'(MAX_RESULTS)) begin
                     wr_data.countdown = cur.interval;
                     wr_en = cur.rpt;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ticks_ff <= '0;
         busy <= 1'b0;
         rsp_strobe <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mode_ff <= req_mode;
                  id_ff <= req_task_id;
                  ivl_ff <= req_interval;
                  rep_ff <= req_repeat_req;
                  pri_ff <= req_priority_req;
                  i_ff <= '0;
                  w_ff <= '0;
                  hit_ff <= 1'b0;
                  ndisp_ff <= '0;
                  status_ff <= STAT_OK;
                  slot_ff <= '0;
                  found_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  pass_ff <= 1'b0;
                  drop_ff <= '0;
                  busy <= 1'b1;
                  if (req_mode == MODE_ADD && count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     status_ff <= STAT_FULL;
                     state_ff <= ST_DONE;
                  end else if (req_mode > MODE_EXISTS) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               if (mode_ff == MODE_ADD ? (hit_ff && !in_range) : !in_range) begin
                  if (mode_ff == MODE_UPDATE && !pass_ff) begin
                     pass_ff <= 1'b1;
                     i_ff <= '0;
                     w_ff <= '0;
                     ndisp_ff <= '0;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               i_ff <= i_ff + 1'b1;
               w_ff <= w_ff + 1'b1;
               state_ff <= ST_READ;
               case (mode_ff)
                  MODE_ADD: begin
                     if (!hit_ff && (!in_range || cur.prio > pri_ff)) begin
                        hit_ff <= 1'b1;
                        slot_ff <= i_ff[IDX_W-1:0];
                        carry_ff <= cur;
                        count_ff <= count_ff + 1'b1;
                     end else if (hit_ff) begin
                        carry_ff <= cur;
                     end
                  end
                  MODE_REMOVE: begin
                     if (!hit_ff && cur.id == id_ff) begin
                        hit_ff <= 1'b1;
                        w_ff <= w_ff;
                     end
                  end
                  MODE_TOUCH, MODE_EXISTS: begin
                     if (cur.id == id_ff) begin
                        hit_ff <= 1'b1;
                        found_ff <= 1'b1;
                        state_ff <= ST_DONE;
                     end
                  end
                  MODE_TICK: ;
                  MODE_UPDATE: begin
                     if (cur.countdown == '0 && ndisp_ff < DISP_W'(MAX_RESULTS)) begin
                        ndisp_ff <= ndisp_ff + 1'b1;
                        if (!pass_ff) begin
                           if (!cur.rpt) begin
                              drop_ff <= drop_ff + 1'b1;
                           end
                        end else begin
                           if (pend_ff) begin
                              rsp_strobe <= 1'b1;
                              rsp_status <= STAT_OK;
                              rsp_dispatch_valid <= 1'b1;
                              rsp_dispatch_id <= pid_ff;
                              rsp_found <= 1'b0;
                              rsp_slot <= '0;
                              rsp_task_count <= 5'(count_ff - drop_ff);
                              rsp_elapsed_time <= ticks_ff;
                              rsp_last <= 1'b0;
                           end
                           pend_ff <= 1'b1;
                           pid_ff <= cur.id;
                           if (!cur.rpt) begin
                              w_ff <= w_ff;
                           end
                        end
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
               busy <= 1'b0;
               rsp_strobe <= 1'b1;
               rsp_status <= status_ff;
               rsp_found <= 1'b0;
               rsp_slot <= 4'(slot_ff);
               rsp_dispatch_valid <= pend_ff;
               rsp_dispatch_id <= pend_ff ? pid_ff : 8'd0;
               rsp_last <= 1'b1;
               rsp_elapsed_time <= mode_ff == MODE_TICK ? ticks_ff + 32'd1 : ticks_ff;
               if (mode_ff == MODE_TICK) begin
                  ticks_ff <= ticks_ff + 32'd1;
               end
               rsp_task_count <= 5'(count_ff);
               if ((mode_ff == MODE_REMOVE || mode_ff == MODE_TOUCH) && !hit_ff) begin
                  rsp_status <= STAT_NOT_FOUND;
               end
               if (mode_ff == MODE_EXISTS) begin
                  rsp_found <= found_ff;
               end
               if (mode_ff == MODE_REMOVE && hit_ff) begin
                  count_ff <= count_ff - 1'b1;
                  rsp_task_count <= 5'(count_ff - 1'b1);
               end
               if (mode_ff == MODE_UPDATE) begin
                  count_ff <= w_ff;
                  rsp_task_count <= 5'(w_ff);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_priority_task_timer_table.sv @@
// Testbench for priority_task_timer_table: drives command words from a queue and checks
// every result word against an in-bench model of the priority ordered timer table.
// Depends on pttt_pkg and the priority_task_timer_table RTL.
`timescale 1ns / 100ps
module tb_priority_task_timer_table;
   import pttt_pkg::*;

   typedef struct {
      logic [2:0] mode;
      logic [7:0] task_id;
      logic [15:0] interval;
      logic rpt;
      logic [7:0] prio;
      int gap;
      bit drain;
   } cmd_word_type;

   typedef struct {
      logic [1:0] status;
      logic dispatch_valid;
      logic [7:0] dispatch_id;
      logic found;
      logic [3:0] slot;
      logic [4:0] task_count;
      logic [31:0] elapsed_time;
      logic last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_mode = '0;
   logic [7:0] req_task_id = '0;
   logic [15:0] req_interval = '0;
   logic req_repeat_req = 1'b0;
   logic [7:0] req_priority_req = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic rsp_dispatch_valid;
   logic [7:0] rsp_dispatch_id;
   logic rsp_found;
   logic [3:0] rsp_slot;
   logic [4:0] rsp_task_count;
   logic [31:0] rsp_elapsed_time;
   logic rsp_last;

   priority_task_timer_table u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cmd_word_type cmd_queue[$];
   rsp_word_type due_words[$];
   entry_type tbl[TABLE_DEPTH];
   int tbl_count = 0;
   logic [31:0] ms_count = '0;
   int fail_count = 0;
   int idle_cycles = 0;
   bit stim_done = 0;

   function automatic int lookup_id(logic [7:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl[i].id == id) return i;
      return tbl_count;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
      tbl_count--;
   endfunction

   function automatic void predict_command(cmd_word_type c);
      logic [1:0] st;
      logic fnd;
      int slt;
      int pos;
      int i;
      logic [7:0] fired[$];
      rsp_word_type w;
      st = STAT_OK;
      fnd = 1'b0;
      slt = 0;
      case (c.mode)
         MODE_ADD: begin
            if (tbl_count >= TABLE_DEPTH) begin
               st = STAT_FULL;
            end else begin
               for (pos = 0; pos < tbl_count; pos++)
                  if (tbl[pos].prio > c.prio) break;
               for (i = tbl_count; i > pos; i--) tbl[i] = tbl[i - 1];
               tbl[pos] = '{c.task_id, c.interval, c.interval, c.rpt, c.prio, 1'b0};
               tbl_count++;
               slt = pos;
            end
         end
         MODE_REMOVE: begin
            pos = lookup_id(c.task_id);
            if (pos >= tbl_count) st = STAT_NOT_FOUND;
            else drop_entry(pos);
         end
         MODE_TOUCH: begin
            pos = lookup_id(c.task_id);
            if (pos >= tbl_count) st = STAT_NOT_FOUND;
            else tbl[pos].countdown = '0;
         end
         MODE_TICK: begin
            for (i = 0; i < tbl_count; i++)
               if (tbl[i].active && tbl[i].countdown != 0) tbl[i].countdown--;
            ms_count++;
         end
         MODE_UPDATE: begin
            for (i = 0; i < tbl_count; i++) tbl[i].active = 1'b1;
            i = 0;
            while (i < tbl_count && fired.size() < MAX_RESULTS) begin
               if (tbl[i].countdown == 0) begin
                  fired.push_back(tbl[i].id);
                  if (tbl[i].rpt) begin
                     tbl[i].countdown = tbl[i].interval;
                     i++;
                  end else begin
                     drop_entry(i);
                  end
               end else begin
                  i++;
               end
            end
         end
         MODE_EXISTS: fnd = lookup_id(c.task_id) < tbl_count;
         default: ;
      endcase
      for (int k = 0; k < (fired.size() > 0 ? fired.size() : 1); k++) begin
         w.status = st;
         w.dispatch_valid = fired.size() > 0;
         w.dispatch_id = fired.size() > 0 ? fired[k] : 8'd0;
         w.found = fnd;
         w.slot = slt[3:0];
         w.task_count = tbl_count[4:0];
         w.elapsed_time = ms_count;
         w.last = (k == (fired.size() > 0 ? fired.size() : 1) - 1);
         due_words.push_back(w);
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic cmd_word_type make_cmd(logic [2:0] m, logic [7:0] id, logic [15:0] iv,
                                             logic r, logic [7:0] p);
      cmd_word_type c;
      c.mode = m;
      c.task_id = id;
      c.interval = iv;
      c.rpt = r;
      c.prio = p;
      c.gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      c.drain = 0;
      return c;
   endfunction

   // Driver: waits out the word's gap, then presents it until accepted.
   int gap_left = -1;
   bit drain_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_command('{req_mode, req_task_id, req_interval, req_repeat_req,
                              req_priority_req, 0, 0});
            void'(cmd_queue.pop_front());
            gap_left = -1;
         end
         if (!(start && busy)) begin
            if (cmd_queue.size() == 0) begin
               start <= 1'b0;
               stim_done = 1;
            end else begin
               if (gap_left < 0) begin
                  gap_left = cmd_queue[0].gap;
                  drain_wait = cmd_queue[0].drain;
               end
               if (drain_wait && due_words.size() == 0 && !busy) drain_wait = 0;
               if (gap_left > 0 || drain_wait) begin
                  if (gap_left > 0) gap_left--;
                  start <= 1'b0;
               end else begin
                  start <= 1'b1;
                  req_mode <= cmd_queue[0].mode;
                  req_task_id <= cmd_queue[0].task_id;
                  req_interval <= cmd_queue[0].interval;
                  req_repeat_req <= cmd_queue[0].rpt;
                  req_priority_req <= cmd_queue[0].prio;
               end
            end
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_words.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               w = due_words.pop_front();
               if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
               if (rsp_dispatch_valid !== w.dispatch_valid)
                  report_mismatch("dispatch_valid", rsp_dispatch_valid, w.dispatch_valid);
               if (rsp_dispatch_id !== w.dispatch_id)
                  report_mismatch("dispatch_id", rsp_dispatch_id, w.dispatch_id);
               if (rsp_found !== w.found) report_mismatch("found", rsp_found, w.found);
               if (rsp_slot !== w.slot) report_mismatch("slot", rsp_slot, w.slot);
               if (rsp_task_count !== w.task_count)
                  report_mismatch("task_count", rsp_task_count, w.task_count);
               if (rsp_elapsed_time !== w.elapsed_time)
                  report_mismatch("elapsed_time", rsp_elapsed_time, w.elapsed_time);
               if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
            end
         end
         if (rsp_strobe || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      cmd_word_type c;
      int ids[$];
      int m;
      // Directed part.
      cmd_queue.push_back(make_cmd(MODE_UPDATE, 8'h00, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_REMOVE, 8'h11, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_TOUCH, 8'hFF, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_ADD, 8'hFF, 16'hFFFF, 1'b1, 8'hFF));
      cmd_queue.push_back(make_cmd(MODE_ADD, 8'h00, 16'h0000, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_ADD, 8'h05, 16'h0001, 1'b1, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_ADD, 8'h05, 16'h0002, 1'b0, 8'h80));
      cmd_queue.push_back(make_cmd(MODE_EXISTS, 8'h05, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_EXISTS, 8'h77, 16'hFFFF, 1'b1, 8'hFF));
      cmd_queue.push_back(make_cmd(3'd6, 8'hAA, 16'h5555, 1'b1, 8'h55));
      cmd_queue.push_back(make_cmd(3'd7, 8'h55, 16'hAAAA, 1'b0, 8'hAA));
      cmd_queue.push_back(make_cmd(MODE_UPDATE, 8'h00, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_TICK, 8'h00, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_TICK, 8'h00, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_TOUCH, 8'hFF, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_UPDATE, 8'h00, 16'h0, 1'b0, 8'h00));
      cmd_queue.push_back(make_cmd(MODE_REMOVE, 8'h05, 16'h0, 1'b0, 8'h00));
      for (int i = 0; i < 17; i++)
         cmd_queue.push_back(make_cmd(MODE_ADD, i[7:0], 16'h0, i[0], 8'h10));
      cmd_queue.push_back(make_cmd(MODE_UPDATE, 8'h00, 16'h0, 1'b0, 8'h00));
      c = make_cmd(MODE_UPDATE, 8'h00, 16'h0, 1'b0, 8'h00);
      c.drain = 1;
      cmd_queue.push_back(c);
      // Random part: mostly timer life cycles with small intervals and a reused id pool.
      for (int n = 0; n < 250; n++) begin
         m = $urandom_range(0, 99);
         if (m < 25) c = make_cmd(MODE_ADD, 8'($urandom_range(0, 15)),
                                  $urandom_range(0, 9) == 0 ? 16'($urandom)
                                  : 16'($urandom_range(0, 4)),
                                  1'($urandom_range(0, 1)), 8'($urandom));
         else if (m < 35) c = make_cmd(MODE_REMOVE, 8'($urandom_range(0, 19)), 16'($urandom),
                                       1'($urandom_range(0, 1)), 8'($urandom));
         else if (m < 43) c = make_cmd(MODE_TOUCH, 8'($urandom_range(0, 19)), 16'($urandom),
                                       1'($urandom_range(0, 1)), 8'($urandom));
         else if (m < 70) c = make_cmd(MODE_TICK, 8'($urandom), 16'($urandom),
                                       1'($urandom_range(0, 1)), 8'($urandom));
         else if (m < 88) c = make_cmd(MODE_UPDATE, 8'($urandom), 16'($urandom),
                                       1'($urandom_range(0, 1)), 8'($urandom));
         else if (m < 96) c = make_cmd(MODE_EXISTS, $urandom_range(0, 1) ? 8'($urandom)
                                       : 8'($urandom_range(0, 15)), 16'($urandom), 1'b0,
                                       8'($urandom));
         else c = make_cmd(3'($urandom_range(6, 7)), 8'($urandom), 16'($urandom),
                           1'($urandom_range(0, 1)), 8'($urandom));
         if (n % 60 == 30) c.drain = 1;
         cmd_queue.push_back(c);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && due_words.size() == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && due_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
